// ===== rtl/mhrs_pkg.sv =====
// shared types, constants and the sigmoid lookup table for the mlp head
package mhrs_pkg;

	localparam int VL         = 16;
	localparam int NUM_MODELS = 7;
	localparam int OFS_B1     = VL * VL;
	localparam int OFS_W2     = OFS_B1 + VL;
	localparam int OFS_B2     = OFS_W2 + VL;
	localparam int SET_WORDS  = OFS_B2 + 1;
	localparam int WS_DEPTH   = NUM_MODELS * SET_WORDS;
	localparam int WADDR_W    = $clog2(WS_DEPTH);
	localparam int SLOT_W     = 9;
	localparam int IDX_W      = $clog2(VL);
	localparam int VADDR_W    = IDX_W + 1;
	localparam int SET_W      = 3;
	localparam int ACC_W      = 40;
	localparam int PROD_W     = 32;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_FEED = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_HOLD
	} seq_state_t;

	// tag travelling with each multiply-accumulate term
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last;
		logic             layer;
		logic [IDX_W-1:0] idx;
	} mac_tag_t;

	// hidden value write back into the vector buffer
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [15:0]      data;
	} hid_wr_t;

	// long division used only while the table is built
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r    = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [15:0] sig_entry(input logic [7:0] idx);
		int          mid;
		logic [63:0] ax;
		logic [63:0] t;
		logic [63:0] k;
		logic [63:0] u;
		logic [63:0] r;
		logic [63:0] e;
		logic [63:0] s;
		mid = (int'(idx) - 128) * 256 + 128;
		ax  = 64'(mid < 0 ? -mid : mid);
		t   = (ax * 64'd94548) >> 12;
		k   = t >> 16;
		u   = ((t & 64'hFFFF) * 64'd45426) >> 16;
		r   = 64'd65536;
		for (int n = 6; n >= 1; n--) begin
			r = 64'd65536 - udiv64(u * r, 64'(n) << 16);
		end
		e = (k < 64'd32) ? (r >> k) : 64'd0;
		if (mid >= 0) begin
			s = udiv64(64'd1 << 32, 64'd65536 + e);
		end else begin
			s = udiv64(e << 16, 64'd65536 + e);
		end
		return (s > 64'd65535) ? 16'hFFFF : s[15:0];
	endfunction

	function automatic logic [256*16-1:0] sig_lut_build();
		logic [256*16-1:0] lut;
		lut = '0;
		for (int i = 0; i < 256; i++) begin
			lut[i*16 +: 16] = sig_entry(8'(i));
		end
		return lut;
	endfunction

	localparam logic [256*16-1:0] SIG_LUT = sig_lut_build();

endpackage

// ===== rtl/mhrs_wstore.sv =====
// weight store: one write port, one registered read port
module mhrs_wstore (
	input  logic                        clk,
	input  logic                        we,
	input  logic [mhrs_pkg::WADDR_W-1:0] waddr,
	input  logic [15:0]                 wdata,
	input  logic [mhrs_pkg::WADDR_W-1:0] raddr,
	output logic [15:0]                 rdata
);
	import mhrs_pkg::*;

	logic [15:0] mem [WS_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/mhrs_vbuf.sv =====
// vector buffer: activations in the lower half, hidden values in the upper half
module mhrs_vbuf (
	input  logic                        clk,
	input  logic                        we,
	input  logic [mhrs_pkg::VADDR_W-1:0] waddr,
	input  logic [15:0]                 wdata,
	input  logic [mhrs_pkg::VADDR_W-1:0] raddr,
	output logic [15:0]                 rdata
);
	import mhrs_pkg::*;

	logic [15:0] mem [2*VL];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/mhrs_mac.sv =====
// shared multiply-accumulate with relu, saturation and sigmoid lookup
module mhrs_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  mhrs_pkg::mac_tag_t  tag_s1,
	input  logic [15:0]         wdata_s1,
	input  logic [15:0]         adata_s1,
	output mhrs_pkg::hid_wr_t   hid,
	output logic                score_valid,
	output logic [15:0]         score
);
	import mhrs_pkg::*;

	mac_tag_t                  tag_s2;
	mac_tag_t                  tag_s3;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-13:0]  shr;
	logic        [15:0]        hval;
	logic        [15:0]        zval;
	logic        [7:0]         lut_idx;
	logic                      fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// bias enters shifted into q8.24
	always_ff @(posedge clk) begin
		if (tag_s1.first) begin
			prod_s2 <= PROD_W'($signed(wdata_s1)) <<< 12;
		end else begin
			prod_s2 <= $signed(wdata_s1) * $signed(adata_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (tag_s2.valid) begin
			if (tag_s2.first) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	assign shr = acc_q[ACC_W-1:12];
	assign fin = tag_s3.valid && tag_s3.last;

	always_comb begin
		if (acc_q[ACC_W-1]) begin
			hval = '0;
		end else if (shr > (ACC_W-12)'(32767)) begin
			hval = 16'h7FFF;
		end else begin
			hval = shr[15:0];
		end
		if (shr > (ACC_W-12)'(32767)) begin
			zval = 16'h7FFF;
		end else if (shr < -(ACC_W-12)'(32768)) begin
			zval = 16'h8000;
		end else begin
			zval = shr[15:0];
		end
		lut_idx = {~zval[15], zval[14:8]};
	end

	assign hid.en   = fin && !tag_s3.layer;
	assign hid.idx  = tag_s3.idx;
	assign hid.data = hval;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_valid <= 1'b0;
		end else begin
			score_valid <= fin && tag_s3.layer;
		end
	end

	always_ff @(posedge clk) begin
		if (fin && tag_s3.layer) begin
			score <= SIG_LUT[{lut_idx, 4'd0} +: 16];
		end
	end

endmodule

// ===== rtl/mlp_head_relu_sigmoid_core.sv =====
// top level: request decode, evaluation sequencer and output register
// Load requests and feed requests without last are taken one per cycle. A feed request
// with last starts an evaluation that issues 289 terms (17 per hidden unit, 17 for the
// output) to one shared multiplier, one weight-store read and one vector-buffer read per
// cycle. The terms then pass the read, multiply and accumulate stages, the sigmoid lookup
// register and the result register before the output register is loaded. Input is held
// off from the accepting edge until the score is loaded into the output register, so no
// new request is taken while an evaluation runs or its score still waits to be loaded.
// The weight store has no reset: every weight of a set and every activation must be
// written before it is used.
module mlp_head_relu_sigmoid_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // set_code[3:0], slot[12:4], value[28:13], zeros
	input  logic        s_axis_tlast,
	input  logic        s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // score
);
	import mhrs_pkg::*;

	seq_state_t          state_q;
	seq_state_t          state_d;
	logic [IDX_W-1:0]    i_q;
	logic [4:0]          j_q;
	logic                layer_q;
	logic [WADDR_W-1:0]  base_q;
	logic [15:0]         res_q;
	mac_tag_t            tag_s1;
	mac_tag_t            tag_s0;

	logic [3:0]          tl;
	logic [SLOT_W-1:0]   slot;
	logic [15:0]         value;
	logic [SET_W-1:0]    set_sel;
	logic [WADDR_W-1:0]  set_base;
	logic                acc;
	logic                issue;
	logic                out_load;
	logic [IDX_W-1:0]    jm1;
	logic [SLOT_W-1:0]   wofs;
	logic [WADDR_W-1:0]  w_raddr;
	logic [WADDR_W-1:0]  w_waddr;
	logic                w_we;
	logic [15:0]         w_rdata;
	logic                v_we;
	logic [VADDR_W-1:0]  v_waddr;
	logic [15:0]         v_wdata;
	logic [VADDR_W-1:0]  v_raddr;
	logic [15:0]         v_rdata;
	hid_wr_t             hid;
	logic                score_valid;
	logic [15:0]         score;

	assign tl    = s_axis_tdata[3:0];
	assign slot  = s_axis_tdata[12:4];
	assign value = s_axis_tdata[28:13];

	// weight set, saturated at both ends
	always_comb begin
		if (tl < 4'd2) begin
			set_sel = '0;
		end else if (tl > 4'(NUM_MODELS + 1)) begin
			set_sel = SET_W'(NUM_MODELS - 1);
		end else begin
			set_sel = SET_W'(tl - 4'd2);
		end
	end

	assign set_base = WADDR_W'(set_sel) * WADDR_W'(SET_WORDS);
	assign acc      = s_axis_tvalid && s_axis_tready;

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		issue         = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && s_axis_tuser == MODE_FEED && s_axis_tlast) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				issue = 1'b1;
				if (layer_q && j_q == 5'(VL)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (score_valid) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q     <= '0;
			j_q     <= '0;
			layer_q <= 1'b0;
			base_q  <= '0;
		end else if (state_q == ST_IDLE) begin
			i_q     <= '0;
			j_q     <= '0;
			layer_q <= 1'b0;
			base_q  <= set_base;
		end else if (issue) begin
			if (j_q == 5'(VL)) begin
				j_q <= '0;
				if (i_q == IDX_W'(VL - 1)) begin
					i_q     <= '0;
					layer_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end else begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	assign jm1 = IDX_W'(j_q - 5'd1);

	always_comb begin
		if (!layer_q) begin
			wofs = (j_q == '0) ? SLOT_W'(OFS_B1) + SLOT_W'(i_q) : SLOT_W'({i_q, jm1});
		end else begin
			wofs = (j_q == '0) ? SLOT_W'(OFS_B2) : SLOT_W'(OFS_W2) + SLOT_W'(jm1);
		end
	end

	assign w_raddr = base_q + WADDR_W'(wofs);
	assign v_raddr = {layer_q, jm1};

	assign tag_s0.valid = issue;
	assign tag_s0.first = (j_q == '0);
	assign tag_s0.last  = (j_q == 5'(VL));
	assign tag_s0.layer = layer_q;
	assign tag_s0.idx   = i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_s0;
		end
	end

	// load requests
	assign w_we    = acc && s_axis_tuser == MODE_LOAD && slot < SLOT_W'(SET_WORDS);
	assign w_waddr = set_base + WADDR_W'(slot);

	// feed requests and hidden write back share the buffer write port
	always_comb begin
		if (hid.en) begin
			v_we    = 1'b1;
			v_waddr = {1'b1, hid.idx};
			v_wdata = hid.data;
		end else begin
			v_we    = acc && s_axis_tuser == MODE_FEED && slot < SLOT_W'(VL);
			v_waddr = {1'b0, slot[IDX_W-1:0]};
			v_wdata = value;
		end
	end

	mhrs_wstore u_wstore (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (value),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	mhrs_vbuf u_vbuf (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	mhrs_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.tag_s1      (tag_s1),
		.wdata_s1    (w_rdata),
		.adata_s1    (v_rdata),
		.hid         (hid),
		.score_valid (score_valid),
		.score       (score)
	);

	always_ff @(posedge clk) begin
		if (score_valid) begin
			res_q <= score;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= res_q;
		end
	end

endmodule
